FILE: src/qss_pkg.sv
package qss_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int NUM_COEFS         = 6;
  localparam int NUM_STEPS         = NUM_COEFS - 1;
  localparam int NUM_LANES         = 3;
  localparam int LANE_POS          = 0;
  localparam int LANE_VEL          = 1;
  localparam int LANE_ACC          = 2;
  localparam int PIPE_LATENCY      = 2 * NUM_STEPS + 2;

  typedef logic signed [31:0] word_t;
  typedef logic [30:0] stime_t;
  typedef word_t [NUM_LANES-1:0] lanes_t;
  typedef word_t [NUM_COEFS-1:0] coef_set_t;
  typedef coef_set_t [NUM_LANES-1:0] coef_bank_t;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_COEF_CONSTANT  = 3'd0;
  localparam reg_idx_t REG_COEF_LINEAR    = 3'd1;
  localparam reg_idx_t REG_COEF_SQUARE    = 3'd2;
  localparam reg_idx_t REG_COEF_CUBE      = 3'd3;
  localparam reg_idx_t REG_COEF_FOURTH    = 3'd4;
  localparam reg_idx_t REG_COEF_FIFTH     = 3'd5;
  localparam reg_idx_t REG_SEGMENT_LENGTH = 3'd6;

  typedef struct packed {
    logic   valid;
    logic   held;
    stime_t t;
  } ctl_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic word_t scale_sat(input word_t c, input logic [4:0] k);
    logic signed [37:0] p;
    p = 38'(c) * $signed({33'd0, k});
    return sat32(64'(p));
  endfunction

endpackage

FILE: src/qss_cfg.sv
module qss_cfg import qss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  reg_idx_t   cfg_index,
  input  logic [31:0] cfg_data,
  output coef_bank_t coef_bank,
  output stime_t     seg_length
);

  coef_set_t  coef_r;
  stime_t     seg_r;
  coef_bank_t bank_r;
  coef_bank_t bank_nxt;

  assign cfg_ready  = 1'b1;
  assign coef_bank  = bank_r;
  assign seg_length = seg_r;

  always_comb begin
    bank_nxt = '0;
    bank_nxt[LANE_POS] = coef_r;
    bank_nxt[LANE_VEL][4] = scale_sat(coef_r[5], 5'd5);
    bank_nxt[LANE_VEL][3] = scale_sat(coef_r[4], 5'd4);
    bank_nxt[LANE_VEL][2] = scale_sat(coef_r[3], 5'd3);
    bank_nxt[LANE_VEL][1] = scale_sat(coef_r[2], 5'd2);
    bank_nxt[LANE_VEL][0] = coef_r[1];
    bank_nxt[LANE_ACC][3] = scale_sat(coef_r[5], 5'd20);
    bank_nxt[LANE_ACC][2] = scale_sat(coef_r[4], 5'd12);
    bank_nxt[LANE_ACC][1] = scale_sat(coef_r[3], 5'd6);
    bank_nxt[LANE_ACC][0] = scale_sat(coef_r[2], 5'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      seg_r  <= '0;
      bank_r <= '0;
    end else begin
      bank_r <= bank_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_COEF_CONSTANT, REG_COEF_LINEAR, REG_COEF_SQUARE,
          REG_COEF_CUBE, REG_COEF_FOURTH, REG_COEF_FIFTH: begin
            coef_r[cfg_index] <= cfg_data;
          end
          REG_SEGMENT_LENGTH: begin
            seg_r <= cfg_data[30:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: src/qss_step.sv
module qss_step import qss_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst_n,
  input  ctl_t   ctl_in,
  input  lanes_t acc_in,
  input  lanes_t coef_in,
  output ctl_t   ctl_out,
  output lanes_t acc_out
);

  logic signed [63:0] prod_r   [NUM_LANES];
  logic signed [63:0] prod_nxt [NUM_LANES];
  ctl_t   mid_r;
  ctl_t   out_r;
  lanes_t acc_r;
  lanes_t acc_nxt;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      prod_nxt[l] = $signed(acc_in[l]) * $signed({1'b0, ctl_in.t});
      acc_nxt[l]  = sat32((prod_r[l] >>> FRAC_BITS) + 64'($signed(coef_in[l])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= '0;
      out_r <= '0;
    end else begin
      mid_r <= ctl_in;
      out_r <= mid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign ctl_out = out_r;
  assign acc_out = acc_r;

endmodule

FILE: src/quintic_spline_sampler_time_bounded.sv
// Samples one quintic segment: each beat on the input gives a single-cycle out_valid beat
// with position, velocity and acceleration; a new sample may be started on every clock, busy
// stays low and results cannot be held off. The path runs through the registered time clamp
// at the front, the five Horner steps, each a registered 32 by 32 multiplier followed by a
// registered shift, add and saturate, and the output register at the end. Position, velocity
// and acceleration run in three parallel lanes. The user must write the coefficients and the
// segment length through the cfg port only while no results are outstanding; the block does
// not enforce this. Derived derivative coefficients settle in the cycle after a write.
module quintic_spline_sampler_time_bounded import qss_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_sample_time,
  output logic               out_valid,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_velocity_out,
  output logic signed [31:0] out_accel_out,
  output logic               out_held,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  coef_bank_t coef_bank;
  stime_t     seg_length;
  ctl_t       ctl0_r;
  ctl_t       ctl0_nxt;
  ctl_t       ctl_chain [NUM_STEPS+1];
  lanes_t     acc_chain [NUM_STEPS+1];
  lanes_t     coef_sel  [NUM_STEPS];
  logic       out_valid_r;
  word_t      pos_r;
  word_t      vel_r;
  word_t      acc_r;
  logic       held_r;

  assign busy = 1'b0;

  qss_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coef_bank  (coef_bank),
    .seg_length (seg_length)
  );

  always_comb begin
    ctl0_nxt.valid = start && !busy;
    ctl0_nxt.held  = 1'b0;
    ctl0_nxt.t     = in_sample_time[30:0];
    if (in_sample_time[31]) begin
      ctl0_nxt.held = 1'b1;
      ctl0_nxt.t    = '0;
    end else if (in_sample_time[30:0] > seg_length) begin
      ctl0_nxt.held = 1'b1;
      ctl0_nxt.t    = seg_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r <= ctl0_nxt;
    end
  end

  always_comb begin
    ctl_chain[0] = ctl0_r;
    for (int l = 0; l < NUM_LANES; l++) begin
      acc_chain[0][l] = coef_bank[l][NUM_COEFS-1];
      for (int s = 0; s < NUM_STEPS; s++) begin
        coef_sel[s][l] = coef_bank[l][NUM_COEFS-2-s];
      end
    end
  end

  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
    qss_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_chain[s]),
      .acc_in  (acc_chain[s]),
      .coef_in (coef_sel[s]),
      .ctl_out (ctl_chain[s+1]),
      .acc_out (acc_chain[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_chain[NUM_STEPS].valid;
    end
    pos_r  <= acc_chain[NUM_STEPS][LANE_POS];
    vel_r  <= ctl_chain[NUM_STEPS].held ? '0 : acc_chain[NUM_STEPS][LANE_VEL];
    acc_r  <= ctl_chain[NUM_STEPS].held ? '0 : acc_chain[NUM_STEPS][LANE_ACC];
    held_r <= ctl_chain[NUM_STEPS].held;
  end

  assign out_valid        = out_valid_r;
  assign out_position_out = pos_r;
  assign out_velocity_out = vel_r;
  assign out_accel_out    = acc_r;
  assign out_held         = held_r;

endmodule

FILE: src/qss_checker.sv
module qss_checker import qss_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_sample_time,
  input logic               out_valid,
  input logic signed [31:0] out_velocity_out,
  input logic signed [31:0] out_accel_out,
  input logic               out_held
);

  // Every accepted beat yields a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("accepted sample produced no result");

  // No result appears without an accepted beat ahead of it.
  a_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without a matching sample");

  // A held result carries no motion.
  a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_held) |-> (out_velocity_out == 0 && out_accel_out == 0))
    else $error("held result with non-zero velocity or acceleration");

  // A negative sample time is always reported as held.
  a_neg_held: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_sample_time[31]) |-> ##PIPE_LATENCY out_held)
    else $error("negative sample time not held");

endmodule

bind quintic_spline_sampler_time_bounded qss_checker u_qss_checker (.*);

FILE: verif/tb_quintic_spline_sampler_time_bounded.sv
module tb_quintic_spline_sampler_time_bounded;
  import qss_pkg::*;

  localparam int FRAC          = FRAC_BITS_DEFAULT;
  localparam int IDLE_LIMIT    = 5000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS   = 128;
  localparam reg_idx_t REG_UNUSED = 3'd7;

  typedef struct packed {
    word_t pos;
    word_t vel;
    word_t acc;
    logic  held;
  } kin_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic signed [31:0] in_sample_time = '0;
  logic               out_valid;
  logic signed [31:0] out_position_out;
  logic signed [31:0] out_velocity_out;
  logic signed [31:0] out_accel_out;
  logic               out_held;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index      = '0;
  logic [31:0]        cfg_data       = '0;

  word_t     pend_q[$];
  kin_t      kin_exp_q[$];
  coef_set_t coef_r    = '0;
  stime_t    seg_len_r = '0;
  int        err_count   = 0;
  int        idle_cycles = 0;
  int        gap_left    = 0;
  int        burst_left  = 0;
  bit        no_gaps     = 1'b0;
  bit        take        = 1'b0;
  kin_t      want;

  quintic_spline_sampler_time_bounded #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_time  (in_sample_time),
    .out_valid       (out_valid),
    .out_position_out(out_position_out),
    .out_velocity_out(out_velocity_out),
    .out_accel_out   (out_accel_out),
    .out_held        (out_held),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic word_t sat_word(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic word_t scaled_coef(input word_t c, input int k);
    logic signed [63:0] c64;
    logic signed [63:0] k64;
    c64 = 64'(c);
    k64 = 64'(k);
    return sat_word(c64 * k64);
  endfunction

  function automatic word_t horner_step(input word_t acc, input word_t t, input word_t k);
    logic signed [63:0] a64;
    logic signed [63:0] t64;
    logic signed [63:0] k64;
    logic signed [63:0] prod;
    a64  = 64'(acc);
    t64  = 64'(t);
    k64  = 64'(k);
    prod = a64 * t64;
    return sat_word((prod >>> FRAC) + k64);
  endfunction

  function automatic word_t horner_eval(input coef_set_t k, input int n, input word_t t);
    word_t acc;
    int    i;
    acc = k[n-1];
    for (i = n - 2; i >= 0; i--) begin
      acc = horner_step(acc, t, k[i]);
    end
    return acc;
  endfunction

  function automatic kin_t predict_kinematics(input word_t ts);
    kin_t      r;
    word_t     t;
    coef_set_t vk;
    coef_set_t ak;
    r  = '0;
    vk = '0;
    ak = '0;
    t  = ts;
    if (ts < 0) begin
      t      = '0;
      r.held = 1'b1;
    end else if (ts[30:0] > seg_len_r) begin
      t      = {1'b0, seg_len_r};
      r.held = 1'b1;
    end
    r.pos = horner_eval(coef_r, 6, t);
    if (!r.held) begin
      vk[0] = coef_r[1];
      vk[1] = scaled_coef(coef_r[2], 2);
      vk[2] = scaled_coef(coef_r[3], 3);
      vk[3] = scaled_coef(coef_r[4], 4);
      vk[4] = scaled_coef(coef_r[5], 5);
      ak[0] = scaled_coef(coef_r[2], 2);
      ak[1] = scaled_coef(coef_r[3], 6);
      ak[2] = scaled_coef(coef_r[4], 12);
      ak[3] = scaled_coef(coef_r[5], 20);
      r.vel = horner_eval(vk, 5, t);
      r.acc = horner_eval(ak, 4, t);
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coef();
    logic [31:0] r;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: r = $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
      5: r = $urandom;
      6: r = '0;
      7: r = 32'h7FFFFFFF;
      8: r = 32'h80000000;
      default: r = $urandom_range(32'h0000_2000, 0) - 32'h0000_1000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_seg();
    logic [30:0] s;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: s = 31'($urandom_range(32'h0004_0000, 1));
      6: s = '0;
      7: s = 31'h7FFFFFFF;
      8: s = 31'($urandom);
      default: s = 31'($urandom_range(32'h0000_1000, 1));
    endcase
    return {1'($urandom), s};
  endfunction

  function automatic word_t rand_time();
    word_t       r;
    int unsigned seg;
    seg = {1'b0, seg_len_r};
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: r = $urandom_range(seg, 0);
      6: begin
        case ($urandom_range(3, 0))
          0: r = '0;
          1: r = seg;
          2: r = seg + 1;
          default: r = -32'sd1;
        endcase
      end
      7: r = {1'b1, 31'($urandom)};
      8: r = $urandom_range(32'h7FFFFFFF, seg);
      default: r = $urandom;
    endcase
    return r;
  endfunction

  task automatic enqueue_sample(input word_t ts);
    pend_q.insert(pend_q.size(), ts);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COEF_CONSTANT, REG_COEF_LINEAR, REG_COEF_SQUARE,
      REG_COEF_CUBE, REG_COEF_FOURTH, REG_COEF_FIFTH: coef_r[idx] = data;
      REG_SEGMENT_LENGTH: seg_len_r = data[30:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] c0, input logic [31:0] c1,
                             input logic [31:0] c2, input logic [31:0] c3,
                             input logic [31:0] c4, input logic [31:0] c5,
                             input logic [31:0] seg);
    @(posedge clk);
    write_reg(REG_COEF_CONSTANT, c0);
    write_reg(REG_COEF_LINEAR, c1);
    write_reg(REG_COEF_SQUARE, c2);
    write_reg(REG_COEF_CUBE, c3);
    write_reg(REG_COEF_FOURTH, c4);
    write_reg(REG_COEF_FIFTH, c5);
    write_reg(REG_SEGMENT_LENGTH, seg);
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_config();
    int       i;
    reg_idx_t idx;
    @(posedge clk);
    for (i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      if ($urandom_range(3, 0) != 0) begin
        if (idx == REG_SEGMENT_LENGTH) begin
          write_reg(idx, rand_seg());
        end else if (idx == REG_UNUSED) begin
          write_reg(idx, $urandom);
        end else begin
          write_reg(idx, rand_coef());
        end
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || start || kin_exp_q.size() != 0) @(negedge clk);
  endtask

  // The sender works in bursts; a gap only starts once the last beat of a burst is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      take = 1'b0;
      if (start && !busy) begin
        kin_exp_q.insert(kin_exp_q.size(), predict_kinematics(in_sample_time));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          take = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
          end
          burst_left--;
          if (burst_left == 0 && !no_gaps) begin
            gap_left = $urandom_range(15, 1);
          end
        end
        if (take) begin
          start          <= 1'b1;
          in_sample_time <= pend_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (kin_exp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected result beat: pos %h vel %h acc %h held %b",
                   out_position_out, out_velocity_out, out_accel_out, out_held);
        end
      end else begin
        want = kin_exp_q.pop_front();
        if (out_position_out !== want.pos || out_velocity_out !== want.vel ||
            out_accel_out !== want.acc || out_held !== want.held) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch: pos %h/%h vel %h/%h acc %h/%h held %b/%b (expected/actual)",
                     want.pos, out_position_out, want.vel, out_velocity_out,
                     want.acc, out_accel_out, want.held, out_held);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: zero duration, so every positive time is held.
    no_gaps = 1'b1;
    enqueue_sample(32'sd0);
    enqueue_sample(32'sd1);
    enqueue_sample(-32'sd1);
    enqueue_sample(32'h7FFFFFFF);
    enqueue_sample(32'h80000000);
    drain();

    load_config(32'h0001_8000, 32'hFFFE_0000, 32'h0000_8000, 32'hFFFF_C000,
                32'h0000_1000, 32'hFFFF_F800, 32'h0002_8000);
    @(negedge clk);
    enqueue_sample(32'sd0);
    enqueue_sample(32'h0002_8000);
    enqueue_sample(32'h0002_8001);
    enqueue_sample(32'h0002_7FFF);
    enqueue_sample(-32'sd1);
    enqueue_sample(32'h0001_0000);
    enqueue_sample(32'h7FFFFFFF);
    enqueue_sample(32'h80000000);
    drain();

    load_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    @(negedge clk);
    no_gaps = 1'b0;
    enqueue_sample(32'h7FFFFFFF);
    enqueue_sample(32'h0001_0000);
    enqueue_sample(32'h0002_0000);
    enqueue_sample(32'sd1);
    enqueue_sample(32'sd0);
    drain();

    load_config(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    @(negedge clk);
    enqueue_sample(32'h7FFFFFFF);
    enqueue_sample(32'h0003_0000);
    enqueue_sample(32'sd2);
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_random_config();
      @(negedge clk);
      no_gaps = ($urandom_range(3, 0) == 0);
      for (k = 0; k < PHASE_BEATS; k++) begin
        enqueue_sample(rand_time());
      end
      drain();
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (err_count == 0 && kin_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
